@@ hdl/gwb_pkg.sv @@
package gwb_pkg;

  localparam int FRAME_PIXELS   = 65536;
  localparam int ADDR_W         = $clog2(FRAME_PIXELS);
  localparam int CHAN_W         = 8;
  localparam int NUM_CH         = 3;
  localparam int CH_W           = $clog2(NUM_CH);
  localparam int PIX_W          = CHAN_W * NUM_CH;
  localparam int SUM_W          = CHAN_W + ADDR_W;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 8 + GAIN_FRAC_BITS;
  localparam int NUM_W          = SUM_W + GAIN_FRAC_BITS + 1;
  localparam int DIV_CNT_W      = $clog2(NUM_W);
  localparam int PROD_W         = CHAN_W + GAIN_W;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic            load;
    logic            last;
    logic            drain;
    logic            peak;
    logic            div_start;
    logic            gain_wr;
    logic [CH_W-1:0] chan;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_ready;
    logic count_last;
    logic div_done;
  } dp_stat_t;

endpackage

@@ hdl/gwb_div.sv @@
module gwb_div
  import gwb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [SUM_W-1:0]  den,
  output logic              done,
  output logic [GAIN_W-1:0] gain
);

  logic                 running;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W-1:0]     den_r;
  logic [NUM_W-1:0]     num_sh;
  logic [NUM_W-1:0]     quo;
  logic [SUM_W:0]       r2;
  logic                 ge;
  logic [SUM_W:0]       diff;

  assign r2   = {rem, num_sh[NUM_W-1]};
  assign ge   = r2 >= {1'b0, den_r};
  assign diff = r2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      den_r  <= den;
      num_sh <= num;
      cnt    <= DIV_CNT_W'(NUM_W - 1);
    end else if (running) begin
      rem    <= ge ? diff[SUM_W-1:0] : r2[SUM_W-1:0];
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      quo    <= {quo[NUM_W-2:0], ge};
      cnt    <= cnt - 1'b1;
    end
  end

  assign gain = (|quo[NUM_W-1:GAIN_W]) ? {GAIN_W{1'b1}} : quo[GAIN_W-1:0];

endmodule

@@ hdl/gwb_dp.sv @@
module gwb_dp
  import gwb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  input  logic [CHAN_W-1:0] chan0_in,
  input  logic [CHAN_W-1:0] chan1_in,
  input  logic [CHAN_W-1:0] chan2_in,
  output dp_stat_t          stat,
  output logic [CHAN_W-1:0] chan0_out,
  output logic [CHAN_W-1:0] chan1_out,
  output logic [CHAN_W-1:0] chan2_out,
  output logic              final_pixel,
  output logic              strobe
);

  localparam logic [GAIN_FRAC_BITS-1:0] HALF = GAIN_FRAC_BITS'(1) << (GAIN_FRAC_BITS - 1);
  localparam int Q_W = PROD_W - GAIN_FRAC_BITS;

  function automatic logic [CHAN_W-1:0] scale_round(input logic [PROD_W-1:0] prod);
    logic [Q_W-1:0]            q;
    logic [GAIN_FRAC_BITS-1:0] fr;
    logic                      up;
    logic [Q_W:0]              qr;
    q  = prod[PROD_W-1:GAIN_FRAC_BITS];
    fr = prod[GAIN_FRAC_BITS-1:0];
    up = (fr > HALF) || (fr == HALF && q[0]);
    qr = {1'b0, q} + (Q_W+1)'(up);
    return (qr > (Q_W+1)'({CHAN_W{1'b1}})) ? {CHAN_W{1'b1}} : qr[CHAN_W-1:0];
  endfunction

  logic [PIX_W-1:0]  mem [FRAME_PIXELS];
  logic [PIX_W-1:0]  rd_data;

  logic [SUM_W-1:0]  sums [NUM_CH];
  logic [SUM_W-1:0]  fs   [NUM_CH];
  logic [SUM_W-1:0]  peak;
  logic [GAIN_W-1:0] gains [NUM_CH];
  logic [ADDR_W-1:0] pixel_count;
  logic [ADDR_W-1:0] read_index;
  logic [ADDR_W-1:0] len_last;
  logic              frame_ready;

  logic [CHAN_W-1:0] pix_in [NUM_CH];
  logic [CHAN_W-1:0] rd_ch  [NUM_CH];
  logic [PROD_W-1:0] prod   [NUM_CH];
  logic              v1, v2, fin1, fin2;

  logic              div_done;
  logic [GAIN_W-1:0] div_gain;
  logic [NUM_W-1:0]  div_num;
  logic              rd_en;

  assign pix_in[0] = chan0_in;
  assign pix_in[1] = chan1_in;
  assign pix_in[2] = chan2_in;
  assign rd_ch[0]  = rd_data[CHAN_W-1:0];
  assign rd_ch[1]  = rd_data[2*CHAN_W-1:CHAN_W];
  assign rd_ch[2]  = rd_data[3*CHAN_W-1:2*CHAN_W];

  assign rd_en   = cmd.drain && frame_ready;
  assign div_num = {1'b0, peak, {GAIN_FRAC_BITS{1'b0}}} + NUM_W'(fs[cmd.chan] >> 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[pixel_count] <= {chan2_in, chan1_in, chan0_in};
    end
    if (rd_en) begin
      rd_data <= mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= '0;
      read_index  <= '0;
      len_last    <= '0;
      frame_ready <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        sums[k]  <= '0;
        gains[k] <= '0;
      end
    end else begin
      if (cmd.load) begin
        if (cmd.last) begin
          for (int k = 0; k < NUM_CH; k++) begin
            sums[k] <= '0;
            fs[k]   <= sums[k] + SUM_W'(pix_in[k]);
          end
          pixel_count <= '0;
          len_last    <= pixel_count;
          frame_ready <= 1'b1;
          read_index  <= '0;
        end else begin
          for (int k = 0; k < NUM_CH; k++) begin
            sums[k] <= sums[k] + SUM_W'(pix_in[k]);
          end
          pixel_count <= pixel_count + 1'b1;
          frame_ready <= 1'b0;
          read_index  <= '0;
        end
      end else if (rd_en) begin
        if (read_index == len_last) begin
          frame_ready <= 1'b0;
          read_index  <= '0;
        end else begin
          read_index <= read_index + 1'b1;
        end
      end
      if (cmd.gain_wr) begin
        gains[cmd.chan] <= (fs[cmd.chan] == '0) ? '0 : div_gain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.peak) begin
      if (fs[0] >= fs[1] && fs[0] >= fs[2]) begin
        peak <= fs[0];
      end else if (fs[1] >= fs[2]) begin
        peak <= fs[1];
      end else begin
        peak <= fs[2];
      end
    end
  end

  gwb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (fs[cmd.chan]),
    .done  (div_done),
    .gain  (div_gain)
  );

  // drain pipe: read, multiply, round
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v1     <= rd_en;
      v2     <= v1;
      strobe <= v2;
    end
  end

  always_ff @(posedge clk) begin
    fin1 <= (read_index == len_last);
    fin2 <= fin1;
    for (int k = 0; k < NUM_CH; k++) begin
      prod[k] <= PROD_W'(rd_ch[k]) * PROD_W'(gains[k]);
    end
    chan0_out   <= scale_round(prod[0]);
    chan1_out   <= scale_round(prod[1]);
    chan2_out   <= scale_round(prod[2]);
    final_pixel <= v2 && fin2;
  end

  assign stat.frame_ready = frame_ready;
  assign stat.count_last  = (pixel_count == ADDR_W'(FRAME_PIXELS - 1));
  assign stat.div_done    = div_done;

endmodule

@@ hdl/gwb_ctrl.sv @@
module gwb_ctrl
  import gwb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      action,
  input  logic      frame_end,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [1:0] {S_IDLE, S_PEAK, S_DIV_START, S_DIV_WAIT} state_t;

  state_t          state;
  logic [CH_W-1:0] chan;
  logic            accept;

  assign accept = start && state == S_IDLE;
  assign busy   = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.last) begin
            state <= S_PEAK;
          end
        end
        S_PEAK: begin
          chan  <= '0;
          state <= S_DIV_START;
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            if (chan == CH_W'(NUM_CH - 1)) begin
              state <= S_IDLE;
            end else begin
              chan  <= chan + 1'b1;
              state <= S_DIV_START;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = accept && action == ACT_LOAD;
    cmd.last      = cmd.load && (frame_end || stat.count_last);
    cmd.drain     = accept && action == ACT_DRAIN;
    cmd.peak      = state == S_PEAK;
    cmd.div_start = state == S_DIV_START;
    cmd.gain_wr   = state == S_DIV_WAIT && stat.div_done;
    cmd.chan      = chan;
  end

endmodule

@@ hdl/gray_world_white_balance.sv @@
// Loads are taken back to back while not busy; a load that ends a frame then holds busy
// while one shared bit-serial divider forms the gains. Drains are taken every cycle while
// not busy; a result shows on strobe after the read, multiply and round registers, and
// the receiver cannot stall. Synchronous reset empties the frame and clears sums and
// gains; the frame store itself is not cleared.
module gray_world_white_balance
  import gwb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [CHAN_W-1:0] chan0_in,
  input  logic [CHAN_W-1:0] chan1_in,
  input  logic [CHAN_W-1:0] chan2_in,
  input  logic              frame_end,
  output logic [CHAN_W-1:0] chan0_out,
  output logic [CHAN_W-1:0] chan1_out,
  output logic [CHAN_W-1:0] chan2_out,
  output logic              final_pixel,
  output logic              strobe
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  gwb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .frame_end (frame_end),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  gwb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .chan0_in    (chan0_in),
    .chan1_in    (chan1_in),
    .chan2_in    (chan2_in),
    .stat        (stat),
    .chan0_out   (chan0_out),
    .chan1_out   (chan1_out),
    .chan2_out   (chan2_out),
    .final_pixel (final_pixel),
    .strobe      (strobe)
  );

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cmd.last))
    else $error("busy rose without a frame-ending load");

  a_strobe_from_drain: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(cmd.drain && stat.frame_ready, 3))
    else $error("result without a drain of a ready frame");

  a_gain_wr_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.gain_wr |-> busy && !cmd.load && !cmd.drain)
    else $error("gain write outside the divide sequence");

endmodule

@@ verif/gray_world_white_balance_tb.sv @@
module gray_world_white_balance_tb;
  import gwb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS = 950;
  localparam longint unsigned GAIN_MAX = (64'd1 << GAIN_W) - 1;

  typedef struct packed {
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
    logic              fin;
  } wb_pix_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              start       = 1'b0;
  logic              action      = ACT_LOAD;
  logic [CHAN_W-1:0] chan0_in    = '0;
  logic [CHAN_W-1:0] chan1_in    = '0;
  logic [CHAN_W-1:0] chan2_in    = '0;
  logic              frame_end   = 1'b0;
  logic              busy;
  logic [CHAN_W-1:0] chan0_out;
  logic [CHAN_W-1:0] chan1_out;
  logic [CHAN_W-1:0] chan2_out;
  logic              final_pixel;
  logic              strobe;

  gray_world_white_balance dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .chan0_in    (chan0_in),
    .chan1_in    (chan1_in),
    .chan2_in    (chan2_in),
    .frame_end   (frame_end),
    .chan0_out   (chan0_out),
    .chan1_out   (chan1_out),
    .chan2_out   (chan2_out),
    .final_pixel (final_pixel),
    .strobe      (strobe)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [PIX_W-1:0]  pix_mem [FRAME_PIXELS];
  longint unsigned   chan_sum [NUM_CH];
  longint unsigned   chan_gain [NUM_CH];
  int unsigned       pix_cnt   = 0;
  int unsigned       rd_idx    = 0;
  int unsigned       frame_len = 0;
  bit                frame_ok  = 0;

  wb_pix_t balanced_q[$];
  wb_pix_t want;
  int      errors       = 0;
  int      useful_items = 0;
  bit      idle_on      = 1;

  initial begin
    foreach (chan_sum[i]) begin
      chan_sum[i]  = 0;
      chan_gain[i] = 0;
    end
  end

  function automatic longint unsigned gray_gain(input longint unsigned peak,
                                                input longint unsigned s);
    longint unsigned g;
    if (s == 0) return 0;
    g = ((peak << GAIN_FRAC_BITS) + (s >> 1)) / s;
    return (g > GAIN_MAX) ? GAIN_MAX : g;
  endfunction

  // round to nearest, ties to even, clip at 255
  function automatic logic [CHAN_W-1:0] apply_gain(input logic [CHAN_W-1:0] v,
                                                   input longint unsigned g);
    longint unsigned prod;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned half;
    prod = longint'(v) * g;
    q    = prod >> GAIN_FRAC_BITS;
    rem  = prod & ((64'd1 << GAIN_FRAC_BITS) - 1);
    half = 64'd1 << (GAIN_FRAC_BITS - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return (q > 255) ? 8'd255 : q[CHAN_W-1:0];
  endfunction

  function automatic bit predict_balance(input logic act, input logic [CHAN_W-1:0] c0,
                                         input logic [CHAN_W-1:0] c1,
                                         input logic [CHAN_W-1:0] c2, input logic fe);
    logic [PIX_W-1:0] px;
    longint unsigned  peak;
    wb_pix_t          r;
    if (act == ACT_LOAD) begin
      if (frame_ok) begin
        frame_ok = 0;
        rd_idx   = 0;
      end
      if (pix_cnt >= FRAME_PIXELS) pix_cnt = 0;
      pix_mem[pix_cnt] = {c2, c1, c0};
      chan_sum[0] += c0;
      chan_sum[1] += c1;
      chan_sum[2] += c2;
      pix_cnt++;
      // a full store closes the frame regardless of frame_end
      if (fe || pix_cnt >= FRAME_PIXELS) begin
        peak = chan_sum[0];
        if (chan_sum[1] > peak) peak = chan_sum[1];
        if (chan_sum[2] > peak) peak = chan_sum[2];
        foreach (chan_gain[i]) begin
          chan_gain[i] = gray_gain(peak, chan_sum[i]);
          chan_sum[i]  = 0;
        end
        frame_len = pix_cnt;
        frame_ok  = 1;
        rd_idx    = 0;
        pix_cnt   = 0;
      end
      return 0;
    end
    if (!frame_ok) return 0;
    px    = pix_mem[rd_idx];
    r.c0  = apply_gain(px[7:0], chan_gain[0]);
    r.c1  = apply_gain(px[15:8], chan_gain[1]);
    r.c2  = apply_gain(px[23:16], chan_gain[2]);
    r.fin = (rd_idx + 1 >= frame_len);
    if (r.fin) begin
      frame_ok = 0;
      rd_idx   = 0;
    end else begin
      rd_idx++;
    end
    balanced_q.push_back(r);
    return 1;
  endfunction

  task automatic check_field(input string what, input logic [CHAN_W-1:0] exp_v,
                             input logic [CHAN_W-1:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) begin
      if (balanced_q.size() == 0) begin
        errors++;
        $display("%0t unexpected pixel: expected none actual %0d %0d %0d %0d", $time,
                 chan0_out, chan1_out, chan2_out, final_pixel);
      end else begin
        want = balanced_q.pop_front();
        check_field("chan0_out", want.c0, chan0_out);
        check_field("chan1_out", want.c1, chan1_out);
        check_field("chan2_out", want.c2, chan2_out);
        check_field("final_pixel", {7'd0, want.fin}, {7'd0, final_pixel});
      end
    end
  end

  // one transfer; start stays high unless a gap follows
  task automatic send_item(input logic act, input logic [CHAN_W-1:0] c0,
                           input logic [CHAN_W-1:0] c1, input logic [CHAN_W-1:0] c2,
                           input logic fe);
    action    <= act;
    chan0_in  <= c0;
    chan1_in  <= c1;
    chan2_in  <= c2;
    frame_end <= fe;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    if (predict_balance(act, c0, c1, c2, fe) || act == ACT_LOAD) useful_items++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic load_pix(input int c0, input int c1, input int c2, input bit fe);
    send_item(ACT_LOAD, c0[7:0], c1[7:0], c2[7:0], fe);
  endtask

  task automatic drain_pix();
    send_item(ACT_DRAIN, CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
              CHAN_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (balanced_q.size() != 0);
  endtask

  task automatic test_drain_without_frame();
    send_item(ACT_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0);
    send_item(ACT_DRAIN, 8'd255, 8'd255, 8'd255, 1'b1);
  endtask

  task automatic test_extremes();
    load_pix(255, 255, 255, 1);
    drain_pix();
    load_pix(0, 0, 0, 1);
    drain_pix();
    drain_pix();
    load_pix(255, 0, 0, 1);
    drain_pix();
  endtask

  // channel 1 gain saturates, channel 2 sum is zero
  task automatic test_gain_limits();
    load_pix(255, 1, 0, 0);
    load_pix(255, 0, 0, 1);
    drain_pix();
    drain_pix();
  endtask

  task automatic test_round_ties();
    load_pix(3, 1, 2, 0);
    load_pix(0, 1, 0, 1);
    drain_pix();
    drain_pix();
    load_pix(4, 1, 1, 0);
    load_pix(1, 1, 1, 1);
    drain_pix();
    drain_pix();
  endtask

  task automatic test_reload_drops_frame();
    load_pix(10, 20, 30, 0);
    load_pix(40, 50, 60, 0);
    load_pix(70, 80, 90, 1);
    drain_pix();
    load_pix(7, 8, 9, 1);
    drain_pix();
    drain_pix();
  endtask

  function automatic int pick_level(input int mode, input int dom, input int ch);
    case (mode)
      0:       return $urandom_range(0, 255);
      1:       return (ch == dom) ? $urandom_range(128, 255) : $urandom_range(0, 3);
      2:       return $urandom_range(0, 1) ? 255 : 0;
      default: return $urandom_range(100, 140);
    endcase
  endfunction

  task automatic test_random_frames();
    int base;
    int len;
    int mode;
    int dom;
    int r;
    int drains;
    bit pressed;
    base    = useful_items;
    pressed = 0;
    idle_on = 1;
    while (useful_items - base < RAND_ITEMS) begin
      if (useful_items - base > RAND_ITEMS * 5 / 6) idle_on = 0;
      if (!pressed && useful_items - base > RAND_ITEMS / 2) begin
        pause_until_drained();
        pressed = 1;
      end
      if ($urandom_range(0, 19) == 0) drain_pix();
      r    = $urandom_range(0, 99);
      len  = (r < 70) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 40)
                                                      : $urandom_range(41, 120);
      mode = $urandom_range(0, 3);
      dom  = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) drain_pix();
        load_pix(pick_level(mode, dom, 0), pick_level(mode, dom, 1),
                 pick_level(mode, dom, 2), i == len - 1);
      end
      r = $urandom_range(0, 99);
      if (r < 75) drains = len + $urandom_range(0, 2);
      else if (r < 90) drains = $urandom_range(0, len - 1);
      else drains = 0;
      for (int i = 0; i < drains; i++) drain_pix();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_drain_without_frame();
    test_extremes();
    test_gain_limits();
    test_round_ties();
    test_reload_drops_frame();
    test_random_frames();
    pause_until_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
